FILE: rtl/ttf_pkg.sv
package ttf_pkg;

	// One triangle corner as it enters
	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [23:0] tex_u;
		logic signed [23:0] tex_v;
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
		logic signed [15:0] norm_z;
	} corner_t;

	// One corner frame as it leaves
	typedef struct packed {
		logic signed [15:0] out_tangent_x;
		logic signed [15:0] out_tangent_y;
		logic signed [15:0] out_tangent_z;
		logic signed [15:0] out_binormal_x;
		logic signed [15:0] out_binormal_y;
		logic signed [15:0] out_binormal_z;
		logic               last_of_face;
	} result_t;

	// Face record passed from front to back: edge deltas and the three normals
	typedef struct packed {
		logic [2:0][32:0]      dp1;
		logic [2:0][32:0]      dp2;
		logic signed [24:0]    dv1;
		logic signed [24:0]    dv2;
		logic [2:0][2:0][15:0] nrm;
	} face_t;

	localparam int unsigned FACE_Q_DEPTH = 2;

endpackage

FILE: rtl/ttf_if.sv
interface ttf_corner_if;
	import ttf_pkg::*;
	logic    valid;
	logic    ready;
	corner_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface ttf_result_if;
	import ttf_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/ttf_front.sv
module ttf_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  ttf_pkg::corner_t in_data,
	output logic             face_valid,
	input  logic             face_pop,
	output ttf_pkg::face_t   face
);
	import ttf_pkg::*;

	logic [1:0]       cnt_q;
	logic [2:0][31:0] p0_q, p1_q, pin;
	logic [23:0]      v0_q, v1_q;
	logic [2:0][15:0] n0_q, n1_q, nin;
	face_t            fq_q [FACE_Q_DEPTH];
	logic             wr_q, rd_q;
	logic [1:0]       fcnt_q;
	logic             third, accept, push;
	face_t            rec;

	assign third  = cnt_q[1];
	assign in_ready = !third || (fcnt_q != 2'(FACE_Q_DEPTH));
	assign accept = in_valid && in_ready;
	assign push   = accept && third;
	assign pin    = {in_data.pos_z, in_data.pos_y, in_data.pos_x};
	assign nin    = {in_data.norm_z, in_data.norm_y, in_data.norm_x};

	// Form the face record from the held corners and the closing corner
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rec.dp1[i] = 33'($signed(p1_q[i])) - 33'($signed(p0_q[i]));
			rec.dp2[i] = 33'($signed(pin[i])) - 33'($signed(p0_q[i]));
		end
		rec.dv1 = 25'($signed(v1_q)) - 25'($signed(v0_q));
		rec.dv2 = 25'(in_data.tex_v) - 25'($signed(v0_q));
		rec.nrm[0] = n0_q;
		rec.nrm[1] = n1_q;
		rec.nrm[2] = nin;
	end

	// Count corners and track queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fcnt_q <= '0;
		end else begin
			if (accept) cnt_q <= third ? 2'd0 : cnt_q + 2'd1;
			if (push) wr_q <= !wr_q;
			if (face_pop) rd_q <= !rd_q;
			fcnt_q <= fcnt_q + 2'(push) - 2'(face_pop);
		end
	end

	// Hold the first two corners, store closed faces
	always_ff @(posedge clk) begin
		if (accept && cnt_q == 2'd0) begin
			p0_q <= pin;
			v0_q <= in_data.tex_v;
			n0_q <= nin;
		end
		if (accept && cnt_q == 2'd1) begin
			p1_q <= pin;
			v1_q <= in_data.tex_v;
			n1_q <= nin;
		end
		if (push) fq_q[wr_q] <= rec;
	end

	assign face_valid = fcnt_q != 2'd0;
	assign face       = fq_q[rd_q];

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		face_pop |-> face_valid) else $error("face popped from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("corner count out of range");
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= 2'(FACE_Q_DEPTH)) else $error("face queue overfilled");

endmodule

FILE: rtl/ttf_back.sv
module ttf_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             face_valid,
	output logic             face_pop,
	input  ttf_pkg::face_t   face,
	output logic             out_valid,
	input  logic             out_ready,
	output ttf_pkg::result_t out_data
);
	import ttf_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RAW   = 4'd1;
	localparam logic [3:0] ST_MAG   = 4'd2;
	localparam logic [3:0] ST_NORM  = 4'd3;
	localparam logic [3:0] ST_SQ    = 4'd4;
	localparam logic [3:0] ST_SQRT  = 4'd5;
	localparam logic [3:0] ST_DIVI  = 4'd6;
	localparam logic [3:0] ST_DIV   = 4'd7;
	localparam logic [3:0] ST_CROSS = 4'd8;
	localparam logic [3:0] ST_EMIT  = 4'd9;

	function automatic logic [15:0] sat16(input logic signed [20:0] x);
		if (x > 21'sd32767) return 16'h7fff;
		if (x < -21'sd32768) return 16'h8000;
		return x[15:0];
	endfunction

	logic [3:0]         st_q;
	logic [4:0]         k_q;
	logic [1:0]         c_q;
	face_t              face_q;
	logic signed [57:0] pa_q, pb_q;
	logic signed [58:0] raw_q [3];
	logic [57:0]        a_q [3];
	logic [57:0]        m_q;
	logic [63:0]        sum_q, x_q, res_q;
	logic [32:0]        rem_q [3];
	logic [15:0]        lo_q [3];
	logic [15:0]        quo_q [3];
	logic signed [17:0] b_q [3];
	logic signed [20:0] tg_q [3];
	result_t            out_q;
	logic               ovalid_q;

	logic               out_free;
	logic [1:0]         ki, rsel;
	logic signed [57:0] pa, pb;
	logic [57:0]        am [3];
	logic [57:0]        amax;
	logic [63:0]        bitv, cand;
	logic [31:0]        s;
	logic [45:0]        num [3];
	logic [32:0]        r2 [3];
	logic               ge [3];
	logic signed [16:0] t [3];
	logic [1:0]         j, u, w;
	logic               ph2;
	logic signed [17:0] opa_u, opa_w, opc_u, opc_w;
	logic signed [36:0] diff, rnd;

	assign out_free = !ovalid_q || out_ready;
	assign face_pop = (st_q == ST_IDLE) && face_valid;
	assign ki       = k_q[1:0];
	assign s        = res_q[31:0];

	// Raw tangent products, one component a cycle
	always_comb begin
		rsel = (ki == 2'd3) ? 2'd0 : ki;
		pa = 58'($signed(face_q.dp1[rsel])) * 58'(face_q.dv2);
		pb = 58'($signed(face_q.dp2[rsel])) * 58'(face_q.dv1);
	end

	// Magnitudes and their maximum
	always_comb begin
		for (int i = 0; i < 3; i++)
			am[i] = raw_q[i][58] ? 58'(-raw_q[i]) : 58'(raw_q[i]);
		amax = am[0];
		if (am[1] > amax) amax = am[1];
		if (am[2] > amax) amax = am[2];
	end

	// Square root step and divider set-up
	always_comb begin
		bitv = 64'(1) << {k_q, 1'b0};
		cand = res_q + bitv;
		for (int i = 0; i < 3; i++) begin
			num[i] = (46'(a_q[i][30:0]) << 14) + 46'(s >> 1);
			r2[i]  = {rem_q[i][31:0], lo_q[i][15]};
			ge[i]  = r2[i] >= {1'b0, s};
			t[i]   = raw_q[i][58] ? -17'($signed({1'b0, quo_q[i]}))
			                      : 17'($signed({1'b0, quo_q[i]}));
		end
	end

	// Cross product component: a_u * c_w - a_w * c_u, rounded to Q2.14
	always_comb begin
		ph2 = k_q >= 5'd3;
		j   = ph2 ? 2'(k_q - 5'd3) : ki;
		case (j)
			2'd0: begin u = 2'd1; w = 2'd2; end
			2'd1: begin u = 2'd2; w = 2'd0; end
			default: begin u = 2'd0; w = 2'd1; end
		endcase
		if (ph2) begin
			opa_u = b_q[u];
			opa_w = b_q[w];
			opc_u = 18'($signed(face_q.nrm[c_q][u]));
			opc_w = 18'($signed(face_q.nrm[c_q][w]));
		end else begin
			opa_u = 18'($signed(face_q.nrm[c_q][u]));
			opa_w = 18'($signed(face_q.nrm[c_q][w]));
			opc_u = 18'(t[u]);
			opc_w = 18'(t[w]);
		end
		diff = 37'(36'(opa_u) * 36'(opc_w)) - 37'(36'(opa_w) * 36'(opc_u));
		rnd  = (diff + 37'sd8192) >>> 14;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			k_q      <= '0;
			c_q      <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (st_q == ST_EMIT && out_free) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
			case (st_q)
				ST_IDLE: if (face_valid) begin
					st_q <= ST_RAW;
					k_q  <= '0;
				end
				ST_RAW: begin
					k_q <= k_q + 5'd1;
					if (ki == 2'd3) st_q <= ST_MAG;
				end
				ST_MAG: begin
					k_q <= '0;
					c_q <= '0;
					st_q <= (amax == '0) ? ST_CROSS : ST_NORM;
				end
				ST_NORM: if (m_q[57:31] == '0 && m_q[30]) begin
					st_q <= ST_SQ;
					k_q  <= '0;
				end
				ST_SQ: begin
					k_q <= k_q + 5'd1;
					if (ki == 2'd2) begin
						st_q <= ST_SQRT;
						k_q  <= 5'd31;
					end
				end
				ST_SQRT: begin
					k_q <= k_q - 5'd1;
					if (k_q == '0) st_q <= ST_DIVI;
				end
				ST_DIVI: begin
					st_q <= ST_DIV;
					k_q  <= 5'd15;
				end
				ST_DIV: begin
					k_q <= k_q - 5'd1;
					if (k_q == '0) begin
						st_q <= ST_CROSS;
						k_q  <= '0;
						c_q  <= '0;
					end
				end
				ST_CROSS: begin
					k_q <= k_q + 5'd1;
					if (k_q == 5'd5) st_q <= ST_EMIT;
				end
				ST_EMIT: if (out_free) begin
					k_q      <= '0;
					if (c_q == 2'd2) begin
						st_q <= ST_IDLE;
					end else begin
						c_q  <= c_q + 2'd1;
						st_q <= ST_CROSS;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: if (face_valid) face_q <= face;
			ST_RAW: begin
				pa_q <= pa;
				pb_q <= pb;
				if (ki != 2'd0) raw_q[ki - 2'd1] <= 59'(pa_q) - 59'(pb_q);
			end
			ST_MAG: begin
				for (int i = 0; i < 3; i++) begin
					a_q[i]   <= am[i];
					quo_q[i] <= '0;
				end
				m_q <= amax;
			end
			ST_NORM: begin
				// Scale all magnitudes by a power of two (shifts of 16, 4 or 1 bits), coarse steps first
				if (m_q[57:47] != '0) begin
					m_q <= m_q >> 16;
					for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] >> 16;
				end else if (m_q[57:35] != '0) begin
					m_q <= m_q >> 4;
					for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] >> 4;
				end else if (m_q[57:31] != '0) begin
					m_q <= m_q >> 1;
					for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] >> 1;
				end else if (m_q[57:14] == '0) begin
					m_q <= m_q << 16;
					for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] << 16;
				end else if (m_q[57:26] == '0) begin
					m_q <= m_q << 4;
					for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] << 4;
				end else if (m_q[57:30] == '0) begin
					m_q <= m_q << 1;
					for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] << 1;
				end
				sum_q <= '0;
			end
			ST_SQ: begin
				sum_q <= sum_q + 64'(a_q[ki][30:0]) * 64'(a_q[ki][30:0]);
				x_q   <= sum_q + 64'(a_q[ki][30:0]) * 64'(a_q[ki][30:0]);
				res_q <= '0;
			end
			ST_SQRT: begin
				if (x_q >= cand) begin
					x_q   <= x_q - cand;
					res_q <= (res_q >> 1) + bitv;
				end else begin
					res_q <= res_q >> 1;
				end
			end
			ST_DIVI: begin
				for (int i = 0; i < 3; i++) begin
					rem_q[i] <= 33'(num[i][45:16]);
					lo_q[i]  <= num[i][15:0];
				end
			end
			ST_DIV: begin
				for (int i = 0; i < 3; i++) begin
					rem_q[i] <= ge[i] ? r2[i] - {1'b0, s} : r2[i];
					lo_q[i]  <= lo_q[i] << 1;
					quo_q[i] <= {quo_q[i][14:0], ge[i]};
				end
			end
			ST_CROSS: begin
				if (ph2) tg_q[j] <= 21'(rnd);
				else b_q[j] <= 18'(rnd);
			end
			ST_EMIT: if (out_free) begin
				out_q.out_tangent_x  <= sat16(tg_q[0]);
				out_q.out_tangent_y  <= sat16(tg_q[1]);
				out_q.out_tangent_z  <= sat16(tg_q[2]);
				out_q.out_binormal_x <= sat16(21'(b_q[0]));
				out_q.out_binormal_y <= sat16(21'(b_q[1]));
				out_q.out_binormal_z <= sat16(21'(b_q[2]));
				out_q.last_of_face   <= c_q == 2'd2;
			end
			default: ;
		endcase
	end

	assign out_valid = ovalid_q;
	assign out_data  = out_q;

	a_pop_starts: assert property (@(posedge clk) disable iff (!arst_n)
		face_pop |=> st_q == ST_RAW) else $error("face pop did not start work");
	a_norm_done: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_SQ |-> (m_q[57:31] == '0 && m_q[30]))
		else $error("magnitudes not normalised");
	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_DIV |-> (res_q[63:32] == '0 && res_q[31:30] != 2'd0))
		else $error("root out of range");
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_EMIT && out_free && c_q == 2'd2) |=> (ovalid_q && out_q.last_of_face))
		else $error("third corner not flagged");

endmodule

FILE: rtl/triangle_tangent_frame.sv
// Per-corner tangent frame for a stream of triangles.
// corner: one beat per triangle corner (position Q16.16, texcoord Q8.16,
//   normal Q2.14), three beats per face in order.
// result: one beat per corner, tangent and binormal in Q2.14 saturated;
//   last_of_face marks the third corner of a face.
// The first two corners of a face are held and give no result. The third
// closes the face into a two-entry face queue; the back end then works the
// face off and emits three beats.
// Per face, the time is set by the bit-serial square root and the shared
// quotient loop; each corner then takes its two cross products. The back
// end takes a new face only once all three beats of the last are emitted.
// A zero-length tangent skips the root and the quotient.
// Corners keep being taken while the back end is busy; only a face's third
// corner waits while the face queue is full. A stalled result holds in the
// output register and the back end waits on it; the front end keeps filling
// the queue. Reset clears the corner count, the queue and the output valid.
module triangle_tangent_frame (
	input logic           clk,
	input logic           arst_n,
	ttf_corner_if.sink    corner,
	ttf_result_if.source  result
);
	import ttf_pkg::*;

	logic  face_valid, face_pop;
	face_t face;

	ttf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (corner.valid),
		.in_ready  (corner.ready),
		.in_data   (corner.data),
		.face_valid(face_valid),
		.face_pop  (face_pop),
		.face      (face)
	);

	ttf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.face_valid(face_valid),
		.face_pop  (face_pop),
		.face      (face),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (result.data)
	);

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import ttf_pkg::*;

	logic clk;
	logic arst_n;

	ttf_corner_if corner_bus();
	ttf_result_if result_bus();

	triangle_tangent_frame dut (
		.clk    (clk),
		.arst_n (arst_n),
		.corner (corner_bus.sink),
		.result (result_bus.source)
	);

	localparam int LIMIT_CYCLES = 400000;

	// predictor state: corners held for the open face
	int          held_count;
	corner_t     held_corner [2];
	result_t     frame_q [$];
	int          errors;
	int          gap_pct;
	int          stall_pct;
	bit          hold_off;
	longint      cycle_cnt;

	// one directed row: a corner, and optionally a typed-in expectation
	typedef struct {
		corner_t  c;
		bit       has_exp;
		result_t  e;
	} row_t;
	row_t rows [$];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint magnitude(longint x);
		return (x < 0) ? -x : x;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// round half up, then floor divide by 2^14
	function automatic longint round_q14(longint x);
		return (x + 8192) >>> 14;
	endfunction

	function automatic logic signed [15:0] clip_q14(longint x);
		if (x > 32767) return 16'sd32767;
		if (x < -32768) return -16'sd32768;
		return x[15:0];
	endfunction

	// unit face tangent in Q2.14 from the raw integer tangent
	task automatic unit_tangent(input longint raw [3], output longint t [3]);
		longint unsigned a [3];
		longint unsigned m;
		longint unsigned sq;
		longint unsigned s;
		m = 0;
		for (int i = 0; i < 3; i++) begin
			a[i] = magnitude(raw[i]);
			if (a[i] > m) m = a[i];
		end
		if (m == 0) begin
			t = '{0, 0, 0};
			return;
		end
		while (m >= (64'd1 << 31)) begin
			m >>= 1;
			for (int i = 0; i < 3; i++) a[i] >>= 1;
		end
		while (m < (64'd1 << 30)) begin
			m <<= 1;
			for (int i = 0; i < 3; i++) a[i] <<= 1;
		end
		sq = 0;
		for (int i = 0; i < 3; i++) sq += a[i] * a[i];
		s = int_sqrt(sq);
		for (int i = 0; i < 3; i++) begin
			longint q;
			q = ((a[i] << 14) + (s >> 1)) / s;
			t[i] = (raw[i] < 0) ? -q : q;
		end
	endtask

	// take one accepted corner; on the third, queue the three frames
	task automatic predict_corner(input corner_t c);
		corner_t f [3];
		longint p [3][3];
		longint t [3];
		longint raw [3];
		longint dv1;
		longint dv2;
		longint n [3];
		longint b [3];
		longint tg [3];
		result_t r;
		if (held_count < 2) begin
			held_corner[held_count] = c;
			held_count++;
			return;
		end
		f[0] = held_corner[0];
		f[1] = held_corner[1];
		f[2] = c;
		for (int k = 0; k < 3; k++) begin
			p[k][0] = f[k].pos_x;
			p[k][1] = f[k].pos_y;
			p[k][2] = f[k].pos_z;
		end
		dv1 = longint'(f[1].tex_v) - longint'(f[0].tex_v);
		dv2 = longint'(f[2].tex_v) - longint'(f[0].tex_v);
		for (int i = 0; i < 3; i++)
			raw[i] = (p[1][i] - p[0][i]) * dv2 - (p[2][i] - p[0][i]) * dv1;
		unit_tangent(raw, t);
		for (int k = 0; k < 3; k++) begin
			n[0] = f[k].norm_x;
			n[1] = f[k].norm_y;
			n[2] = f[k].norm_z;
			b[0] = round_q14(n[1] * t[2] - n[2] * t[1]);
			b[1] = round_q14(n[2] * t[0] - n[0] * t[2]);
			b[2] = round_q14(n[0] * t[1] - n[1] * t[0]);
			tg[0] = round_q14(b[1] * n[2] - b[2] * n[1]);
			tg[1] = round_q14(b[2] * n[0] - b[0] * n[2]);
			tg[2] = round_q14(b[0] * n[1] - b[1] * n[0]);
			r.out_tangent_x  = clip_q14(tg[0]);
			r.out_tangent_y  = clip_q14(tg[1]);
			r.out_tangent_z  = clip_q14(tg[2]);
			r.out_binormal_x = clip_q14(b[0]);
			r.out_binormal_y = clip_q14(b[1]);
			r.out_binormal_z = clip_q14(b[2]);
			r.last_of_face   = (k == 2);
			frame_q = {frame_q, r};
		end
		held_count = 0;
	endtask

	function automatic corner_t mk_corner(int px, int py, int pz, int tu, int tv,
		int nx, int ny, int nz);
		corner_t c;
		c.pos_x = px; c.pos_y = py; c.pos_z = pz;
		c.tex_u = tu[23:0]; c.tex_v = tv[23:0];
		c.norm_x = nx[15:0]; c.norm_y = ny[15:0]; c.norm_z = nz[15:0];
		return c;
	endfunction

	function automatic corner_t rand_corner(bit wild);
		corner_t c;
		c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		if (!wild) begin
			// tame positions and v texcoords, unit-ish normals
			c.pos_x = $signed($urandom_range(0, 2 ** 22)) - (2 ** 21);
			c.pos_y = $signed($urandom_range(0, 2 ** 22)) - (2 ** 21);
			c.pos_z = $signed($urandom_range(0, 2 ** 22)) - (2 ** 21);
			c.tex_v = 24'($signed($urandom_range(0, 2 ** 18)) - (2 ** 17));
			c.norm_x = 16'($signed($urandom_range(0, 32768)) - 16384);
			c.norm_y = 16'($signed($urandom_range(0, 32768)) - 16384);
			c.norm_z = 16'($signed($urandom_range(0, 32768)) - 16384);
		end
		return c;
	endfunction

	function automatic bit chance(int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	task automatic add_row(input corner_t c, input bit has_exp, input result_t e);
		row_t rw;
		rw.c = c;
		rw.has_exp = has_exp;
		rw.e = e;
		rows = {rows, rw};
	endtask

	// send one corner beat, with random gaps before it
	task automatic send_corner(input corner_t c);
		while (chance(gap_pct)) begin
			corner_bus.valid <= 1'b0;
			@(negedge clk);
		end
		corner_bus.valid <= 1'b1;
		corner_bus.data  <= c;
		@(posedge clk);
		while (!corner_bus.ready) @(posedge clk);
		predict_corner(c);
		@(negedge clk);
	endtask

	// drop valid once a run of corners is done
	task automatic stop_corners();
		corner_bus.valid <= 1'b0;
		@(negedge clk);
	endtask

	// receiver: random stall, long hold-off on request
	always @(negedge clk) begin
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
		end else begin
			result_bus.ready <= !hold_off && !chance(stall_pct);
		end
	end

	// check each result beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (frame_q.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, result_bus.data);
				errors++;
			end else begin
				result_t e;
				e = frame_q.pop_front();
				if (e !== result_bus.data) begin
					$display("%0t: mismatch expected %h actual %h",
						$time, e, result_bus.data);
					errors++;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("[triangle_tangent_frame] ERROR");
			$finish;
		end
	end

	task automatic wait_drained();
		while (frame_q.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic random_faces(int n_corners, int gp, int sp);
		gap_pct = gp;
		stall_pct = sp;
		for (int i = 0; i < n_corners; i++)
			send_corner(rand_corner(chance(20)));
		stop_corners();
	endtask

	// long receiver hold-off, counted in its own process
	task automatic hold_results(int cycles);
		hold_off = 1'b1;
		repeat (cycles) @(posedge clk);
		hold_off = 1'b0;
	endtask

	initial begin
		result_t zero_last;
		result_t zero_mid;
		row_t rw;
		errors = 0;
		held_count = 0;
		gap_pct = 0;
		stall_pct = 0;
		hold_off = 1'b0;
		cycle_cnt = 0;
		arst_n = 1'b0;
		corner_bus.valid = 1'b0;
		corner_bus.data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		zero_mid = '0;
		zero_last = '0;
		zero_last.last_of_face = 1'b1;

		// degenerate face: equal texcoords give a zero tangent
		add_row(mk_corner(0, 0, 0, 0, 0, 16384, 0, 0), 1'b0, zero_mid);
		add_row(mk_corner(65536, 0, 0, 0, 0, 0, 16384, 0), 1'b0, zero_mid);
		add_row(mk_corner(0, 65536, 0, 0, 0, 0, 0, 16384), 1'b1, zero_last);
		// extremes of positions, texcoords and normals
		add_row(mk_corner(-2147483647 - 1, 2147483647, -2147483647 - 1,
			-8388608, -8388608, -32768, 32767, -32768), 1'b0, zero_mid);
		add_row(mk_corner(2147483647, -2147483647 - 1, 2147483647,
			8388607, 8388607, 32767, -32768, 32767), 1'b0, zero_mid);
		add_row(mk_corner(-2147483647 - 1, -2147483647 - 1, 2147483647,
			-8388608, -8388608, -32768, -32768, -32768), 1'b0, zero_mid);
		// plain unit face with axis normals
		add_row(mk_corner(0, 0, 0, 0, 0, 0, 0, 16384), 1'b0, zero_mid);
		add_row(mk_corner(65536, 0, 0, 65536, 0, 0, 0, 16384), 1'b0, zero_mid);
		add_row(mk_corner(0, 65536, 0, 0, 65536, 0, 0, 16384), 1'b0, zero_mid);
		// zero normals on every corner give zero frames
		add_row(mk_corner(0, 0, 0, 0, 0, 0, 0, 0), 1'b0, zero_mid);
		add_row(mk_corner(65536, 0, 0, 0, 0, 0, 0, 0), 1'b0, zero_mid);
		add_row(mk_corner(0, 0, 65536, 0, 65536, 0, 0, 0), 1'b0, zero_mid);
		// large normals that push the binormal past the output range
		add_row(mk_corner(1000, 0, 0, 0, 0, 32767, 32767, 0), 1'b0, zero_mid);
		add_row(mk_corner(0, 1000, 0, 0, 0, -32768, -32768, 32767), 1'b0, zero_mid);
		add_row(mk_corner(0, 0, 1000, 0, 5, 32767, -32768, -32768), 1'b0, zero_mid);

		// typed-in frames of the degenerate face must match the queued ones,
		// which the result checker then holds the block to
		foreach (rows[i]) begin
			rw = rows[i];
			send_corner(rw.c);
			if (rw.has_exp && frame_q.size() == 3) begin
				for (int k = 0; k < 3; k++) begin
					if (frame_q[k] !== ((k == 2) ? rw.e : zero_mid)) begin
						$display("%0t: mismatch expected %h actual %h",
							$time, (k == 2) ? rw.e : zero_mid, frame_q[k]);
						errors++;
					end
				end
			end
		end
		stop_corners();
		wait_drained();

		// random phases across idling mixes
		random_faces(30, 0, 0);
		random_faces(30, 45, 0);
		random_faces(30, 0, 45);
		random_faces(30, 32, 32);

		// fill the face queue behind a long receiver hold-off
		gap_pct = 0;
		stall_pct = 0;
		fork
			hold_results(600);
			begin
				for (int i = 0; i < 12; i++) send_corner(rand_corner(1'b0));
				stop_corners();
			end
		join
		// pause the sender until every frame is out
		wait_drained();
		random_faces(12, 20, 20);

		wait_drained();
		repeat (100) @(posedge clk);
		if (errors == 0 && frame_q.size() == 0) begin
			$display("[triangle_tangent_frame] OK");
		end else begin
			$display("[triangle_tangent_frame] ERROR");
		end
		$finish;
	end

endmodule
